### rtl/llth_pkg.sv
// ----------------------------------------------------------------------------
// llth_pkg
// Request and status codes and sequencer states for the least-loaded target heap.
// ----------------------------------------------------------------------------
package llth_pkg;

  localparam logic [2:0] REQ_SET_CAP   = 3'd0;
  localparam logic [2:0] REQ_ADD       = 3'd1;
  localparam logic [2:0] REQ_REMOVE    = 3'd2;
  localparam logic [2:0] REQ_ACQ_GROUP = 3'd3;
  localparam logic [2:0] REQ_ACQ_TGT   = 3'd4;
  localparam logic [2:0] REQ_RELEASE   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_CAP    = 3'd1;
  localparam logic [2:0] ST_IN_GROUP  = 3'd2;
  localparam logic [2:0] ST_NOT_IN    = 3'd3;
  localparam logic [2:0] ST_BAD_CAP   = 3'd4;
  localparam logic [2:0] ST_HEAP_FULL = 3'd5;
  localparam logic [2:0] ST_REL_ZERO  = 3'd6;

  localparam int SUM_BITS = 20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_CMP,
    S_UP_MOVE,
    S_DN_SETUP,
    S_DN_CMP_LR,
    S_DN_CMP_T,
    S_DN_MOVE,
    S_PLACE,
    S_DONE
  } state_t;

  // what to do after a sift up finishes
  typedef enum logic [1:0] {
    AFTER_NONE,
    AFTER_DOWN
  } after_t;

endpackage

### rtl/least_loaded_target_heap_core.sv
// ----------------------------------------------------------------------------
// least_loaded_target_heap_core
// A request with no heap move passes S_DECODE and S_DONE; done strobes once
// the core is back in idle, and the next start is taken in that cycle; no start
// is taken while busy. Each level climbed takes S_UP_CMP and S_UP_MOVE, each
// level descended S_DN_SETUP, S_DN_CMP_LR (two children), S_DN_CMP_T, S_DN_MOVE.
// One shared multiplier pair does every load-ratio compare. The receiver cannot
// stall. Synchronous reset clears loads, limits, membership and sums.
// ----------------------------------------------------------------------------
module least_loaded_target_heap_core #(
  parameter int NUM_TARGETS = 16,
  parameter int LOAD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [3:0]  target_id,
  input  logic [15:0] capacity,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  granted_target,
  output logic [15:0] target_load,
  output logic [19:0] group_load
);

  localparam int IW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int CW = $clog2(NUM_TARGETS + 1);
  localparam int SW = LOAD_BITS + IW + 1;
  localparam int PW = 2 * LOAD_BITS;
  localparam logic [SW-1:0] SAT = SW'((64'd1 << llth_pkg::SUM_BITS) - 64'd1);

  logic [LOAD_BITS-1:0] load_count [NUM_TARGETS];
  logic [LOAD_BITS-1:0] load_limit [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] member_flag;
  logic [IW-1:0] heap_position [NUM_TARGETS];
  logic [IW-1:0] heap_entries [NUM_TARGETS];
  logic [CW-1:0] heap_count;
  logic [SW-1:0] group_load_sum, group_limit_sum;

  llth_pkg::state_t state;
  llth_pkg::after_t after;
  logic [2:0]  req;
  logic [3:0]  id;
  logic [LOAD_BITS-1:0] cap;
  logic        id_ok;
  logic [IW-1:0] tid;
  logic [IW-1:0] pos;
  logic [IW-1:0] best;
  logic        pass_eq;
  logic [2:0]  st;
  logic [3:0]  gr;

  // shared compare unit: ratio(a) vs ratio(b)
  logic [IW-1:0] ca, cb;
  logic [PW-1:0] pa, pb;
  logic lt, eq;
  always_comb begin
    pa = PW'(load_count[ca]) * PW'(load_limit[cb]);
    pb = PW'(load_count[cb]) * PW'(load_limit[ca]);
    lt = pa < pb;
    eq = pa == pb;
  end

  logic [IW:0] up_idx, l_idx, r_idx;
  always_comb begin
    up_idx = ({1'b0, pos} - 1'b1) >> 1;
    l_idx  = {pos, 1'b1};
    r_idx  = l_idx + 1'b1;
  end

  logic [IW-1:0] parent_e, l_e, r_e;
  always_comb begin
    parent_e = heap_entries[up_idx[IW-1:0]];
    l_e = heap_entries[l_idx[IW-1:0]];
    r_e = heap_entries[r_idx[IW-1:0]];
    ca = tid;
    cb = parent_e;
    case (state)
      llth_pkg::S_DN_CMP_LR: begin
        ca = r_e;
        cb = l_e;
      end
      llth_pkg::S_DN_CMP_T: begin
        ca = heap_entries[best];
        cb = tid;
      end
      default: ;
    endcase
  end

  assign busy = state != llth_pkg::S_IDLE;
  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = heap_count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llth_pkg::S_IDLE;
      member_flag <= '0;
      heap_count <= '0;
      group_load_sum <= '0;
      group_limit_sum <= '0;
      done <= 1'b0;
      for (int i = 0; i < NUM_TARGETS; i++) begin
        load_count[i] <= '0;
        load_limit[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        llth_pkg::S_IDLE: begin
          if (start) begin
            req <= req_type;
            id <= target_id;
            cap <= LOAD_BITS'(capacity);
            id_ok <= 32'(target_id) < NUM_TARGETS;
            tid <= IW'(target_id);
            st <= llth_pkg::ST_OK;
            gr <= target_id;
            after <= llth_pkg::AFTER_NONE;
            pass_eq <= 1'b0;
            state <= llth_pkg::S_DECODE;
          end
        end
        llth_pkg::S_DECODE: begin
          state <= llth_pkg::S_DONE;
          if (req > llth_pkg::REQ_RELEASE) begin
            st <= llth_pkg::ST_BAD_CAP;
          end else if (req == llth_pkg::REQ_ACQ_GROUP) begin
            if (heap_count == '0 || group_load_sum >= group_limit_sum) begin
              st <= llth_pkg::ST_NO_CAP;
              gr <= '0;
            end else begin
              tid <= heap_entries[0];
              gr <= 4'(heap_entries[0]);
              load_count[heap_entries[0]] <= load_count[heap_entries[0]] + 1'b1;
              group_load_sum <= group_load_sum + 1'b1;
              pos <= '0;
              state <= llth_pkg::S_DN_SETUP;
            end
          end else if (!id_ok) begin
            st <= llth_pkg::ST_NOT_IN;
          end else begin
            case (req)
              llth_pkg::REQ_SET_CAP: begin
                if (cap == '0) begin
                  st <= llth_pkg::ST_BAD_CAP;
                end else begin
                  load_limit[tid] <= cap;
                  if (member_flag[tid]) begin
                    group_limit_sum <= group_limit_sum - SW'(load_limit[tid]) + SW'(cap);
                    pos <= heap_position[tid];
                    after <= llth_pkg::AFTER_DOWN;
                    state <= llth_pkg::S_UP_CMP;
                  end
                end
              end
              llth_pkg::REQ_ADD: begin
                if (member_flag[tid]) st <= llth_pkg::ST_IN_GROUP;
                else if (load_limit[tid] == '0) st <= llth_pkg::ST_BAD_CAP;
                else if (32'(heap_count) >= NUM_TARGETS) st <= llth_pkg::ST_HEAP_FULL;
                else begin
                  pos <= IW'(heap_count);
                  heap_count <= heap_count + 1'b1;
                  member_flag[tid] <= 1'b1;
                  group_limit_sum <= group_limit_sum + SW'(load_limit[tid]);
                  group_load_sum <= group_load_sum + SW'(load_count[tid]);
                  state <= llth_pkg::S_UP_CMP;
                end
              end
              llth_pkg::REQ_REMOVE: begin
                if (!member_flag[tid]) st <= llth_pkg::ST_NOT_IN;
                else begin
                  member_flag[tid] <= 1'b0;
                  group_limit_sum <= group_limit_sum - SW'(load_limit[tid]);
                  group_load_sum <= group_load_sum - SW'(load_count[tid]);
                  heap_count <= cnt_m1;
                  if (heap_position[tid] != IW'(cnt_m1)) begin
                    tid <= heap_entries[IW'(cnt_m1)];
                    pos <= heap_position[tid];
                    after <= llth_pkg::AFTER_DOWN;
                    state <= llth_pkg::S_UP_CMP;
                  end
                end
              end
              llth_pkg::REQ_ACQ_TGT: begin
                if (load_count[tid] >= load_limit[tid]) st <= llth_pkg::ST_NO_CAP;
                else begin
                  load_count[tid] <= load_count[tid] + 1'b1;
                  if (member_flag[tid]) begin
                    group_load_sum <= group_load_sum + 1'b1;
                    pos <= heap_position[tid];
                    state <= llth_pkg::S_DN_SETUP;
                  end
                end
              end
              default: begin
                if (load_count[tid] == '0) st <= llth_pkg::ST_REL_ZERO;
                else begin
                  load_count[tid] <= load_count[tid] - 1'b1;
                  if (member_flag[tid]) begin
                    group_load_sum <= group_load_sum - 1'b1;
                    pass_eq <= (load_count[tid] - 1'b1) < load_limit[tid];
                    pos <= heap_position[tid];
                    state <= llth_pkg::S_UP_CMP;
                  end
                end
              end
            endcase
          end
        end
        llth_pkg::S_UP_CMP: begin
          if (pos != '0 && (lt || (pass_eq && eq))) state <= llth_pkg::S_UP_MOVE;
          else begin
            heap_entries[pos] <= tid;
            heap_position[tid] <= pos;
            state <= (after == llth_pkg::AFTER_DOWN) ? llth_pkg::S_DN_SETUP
                                                     : llth_pkg::S_DONE;
          end
        end
        llth_pkg::S_UP_MOVE: begin
          heap_entries[pos] <= parent_e;
          heap_position[parent_e] <= pos;
          pos <= up_idx[IW-1:0];
          state <= llth_pkg::S_UP_CMP;
        end
        llth_pkg::S_DN_SETUP: begin
          best <= l_idx[IW-1:0];
          if (l_idx >= (IW+1)'(heap_count)) state <= llth_pkg::S_PLACE;
          else if (r_idx < (IW+1)'(heap_count)) state <= llth_pkg::S_DN_CMP_LR;
          else state <= llth_pkg::S_DN_CMP_T;
        end
        llth_pkg::S_DN_CMP_LR: begin
          if (lt) best <= r_idx[IW-1:0];
          state <= llth_pkg::S_DN_CMP_T;
        end
        llth_pkg::S_DN_CMP_T: begin
          state <= lt ? llth_pkg::S_DN_MOVE : llth_pkg::S_PLACE;
        end
        llth_pkg::S_DN_MOVE: begin
          heap_entries[pos] <= heap_entries[best];
          heap_position[heap_entries[best]] <= pos;
          pos <= best;
          state <= llth_pkg::S_DN_SETUP;
        end
        llth_pkg::S_PLACE: begin
          heap_entries[pos] <= tid;
          heap_position[tid] <= pos;
          state <= llth_pkg::S_DONE;
        end
        llth_pkg::S_DONE: begin
          done <= 1'b1;
          status <= st;
          granted_target <= gr;
          if (req == llth_pkg::REQ_ACQ_GROUP)
            target_load <= (st == llth_pkg::ST_OK) ? 16'(load_count[IW'(gr)]) : '0;
          else
            target_load <= id_ok ? 16'(load_count[IW'(id)]) : '0;
          group_load <= 20'((group_load_sum > SAT) ? SAT : group_load_sum);
          state <= llth_pkg::S_IDLE;
        end
        default: state <= llth_pkg::S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (rst) 32'(heap_count) <= NUM_TARGETS)
    else $error("heap count overflow");
  assert property (@(posedge clk) disable iff (rst)
    $countones(member_flag) == 32'(heap_count))
    else $error("membership and heap count differ");

endmodule
